// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA channel sequencer package
// Shared widths, codes and record types of the DMA channel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

   localparam int CH_W    = 3;   // channel index width
   localparam int LANES   = 8;   // channels a 3-bit index can name
   localparam int COUNT_W = 32;  // byte count width
   localparam int ADDR_W  = 32;  // memory and device address width
   localparam int VEC_W   = 8;   // interrupt vector width

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_XFER   = 1'b1;

   // Per-channel context.
   typedef struct packed {
      logic [COUNT_W-1:0] remaining;
      logic [ADDR_W-1:0]  mem_cursor;
      logic [ADDR_W-1:0]  dev_cursor;
      logic               direction;
      logic [VEC_W-1:0]   vector;
   } chan_entry_type;

   // One result word.
   typedef struct packed {
      logic               kind;
      logic               accepted;
      logic [CH_W-1:0]    channel;
      logic               direction;
      logic [ADDR_W-1:0]  mem_addr;
      logic [ADDR_W-1:0]  dev_addr;
      logic               irq;
      logic [VEC_W-1:0]   vector;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/dcs_chan_file.sv =====
// ----------------------------------------------------------------------------
// DMA channel context file
// Holds the context of every channel, with one read and one write port and
// an active flag per channel that is set while bytes remain.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_chan_file #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [IDX_W-1:0]       rd_idx,
   output dcs_pkg::chan_entry_type rd_entry,
   output logic [DEPTH-1:0]       active,
   input  wire                    wr_en,
   input  wire  [IDX_W-1:0]       wr_idx,
   input  wire dcs_pkg::chan_entry_type wr_entry
);
   import dcs_pkg::*;

   chan_entry_type   entry_ff [DEPTH];
   logic [DEPTH-1:0] active_ff;

   // The context itself needs no reset: it is read only while active.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (wr_en) begin
         active_ff[wr_idx] <= |wr_entry.remaining;
      end
   end

   assign rd_entry = entry_ff[rd_idx];
   assign active   = active_ff;

endmodule

`default_nettype wire

// ===== hdl/dcs_xfer_unit.sv =====
// ----------------------------------------------------------------------------
// DMA transfer step unit
// Moves one channel context forward by one byte: count down, both cursors up,
// and flags the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_xfer_unit (
   input  wire dcs_pkg::chan_entry_type cur_entry,
   output dcs_pkg::chan_entry_type next_entry,
   output logic                    final_byte
);
   import dcs_pkg::*;

   always_comb begin
      next_entry            = cur_entry;
      next_entry.remaining  = cur_entry.remaining - COUNT_W'(1);
      next_entry.mem_cursor = cur_entry.mem_cursor + ADDR_W'(1);
      next_entry.dev_cursor = cur_entry.dev_cursor + ADDR_W'(1);
      final_byte            = (cur_entry.remaining == COUNT_W'(1));
   end

endmodule

`default_nettype wire

// ===== hdl/dma_channel_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// DMA channel sequencer core
// Multi-channel byte DMA sequencer: loads channel requests and, on each tick,
// issues one byte-transfer command per active channel in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one word per operation. With opcode request it
// loads a channel (direction, byte count, both start addresses, vector) if
// that channel exists and has no bytes left; the block answers with one rsp_
// word whose accepted bit tells the outcome. A request with a zero count is
// accepted and leaves the channel idle. With opcode tick the block visits
// every channel in ascending order, one channel per cycle unless a held
// result stalls it, through a single shared step unit, and sends one transfer
// command word per active channel; the command for a channel's final byte
// carries raise_interrupt and the channel's vector, and the last word of a
// tick carries last_of_run. A tick with no active channel sends nothing.
// A request first latches its word, then loads its channel and registers
// the answer at the same edge. A tick visits min(NUM_CHANNELS, 8) channels,
// stepped by the visit pointer of the scan. A held result that blocks an
// answer or an active channel holds the sequencer until it drains. The block
// takes a new req_ word only when the previous one is finished.
// Reset marks every channel idle and empties the result register.
// When the receiver stalls, the held result stays on rsp_ and the scan waits
// on the channel it is visiting; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_channel_sequencer_core #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   // Request channel
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_opcode,
   input  wire  [dcs_pkg::CH_W-1:0]    req_channel_index,
   input  wire                         req_to_memory,
   input  wire  [dcs_pkg::COUNT_W-1:0] req_byte_count,
   input  wire  [dcs_pkg::ADDR_W-1:0]  req_memory_start,
   input  wire  [dcs_pkg::ADDR_W-1:0]  req_device_start,
   input  wire  [dcs_pkg::VEC_W-1:0]   req_interrupt_vector,
   // Result channel
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic                        rsp_kind,
   output logic                        rsp_accepted,
   output logic [dcs_pkg::CH_W-1:0]    rsp_channel_out,
   output logic                        rsp_direction_out,
   output logic [dcs_pkg::ADDR_W-1:0]  rsp_memory_address,
   output logic [dcs_pkg::ADDR_W-1:0]  rsp_device_address,
   output logic                        rsp_raise_interrupt,
   output logic [dcs_pkg::VEC_W-1:0]   rsp_vector_out,
   output logic                        rsp_last_of_run
);
   import dcs_pkg::*;

   // Only channels below both the parameter and the index range exist.
   localparam int DEPTH = (NUM_CHANNELS < LANES) ? NUM_CHANNELS : LANES;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REQ  = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;

   // Sequencer state and the visit pointer of a tick.
   logic [1:0]      state_ff, state_in;
   logic [CH_W-1:0] ptr_ff, ptr_in;

   // Latched request word.
   logic [CH_W-1:0]    rq_ch_ff, rq_ch_in;
   logic               rq_dir_ff, rq_dir_in;
   logic [COUNT_W-1:0] rq_count_ff, rq_count_in;
   logic [ADDR_W-1:0]  rq_mem_ff, rq_mem_in;
   logic [ADDR_W-1:0]  rq_dev_ff, rq_dev_in;
   logic [VEC_W-1:0]   rq_vec_ff, rq_vec_in;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   // Channel file and step unit connections.
   chan_entry_type   rd_entry;
   chan_entry_type   stepped;
   chan_entry_type   wr_entry;
   logic [DEPTH-1:0] active;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic             final_byte;

   logic             out_free;
   logic             rq_in_range;
   logic             rq_ok;
   logic             higher_active;
   logic             scan_done;

   dcs_chan_file #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_chan_file (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (ptr_ff[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .active   (active),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry)
   );

   dcs_xfer_unit u_xfer_unit (
      .cur_entry  (rd_entry),
      .next_entry (stepped),
      .final_byte (final_byte)
   );

   // The result register can take a new word when empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // A request is taken only for an existing, idle channel. The compare is
   // one bit wider so that a depth of eight still fits.
   assign rq_in_range = ((CH_W+1)'(rq_ch_ff) < (CH_W+1)'(DEPTH));
   assign rq_ok       = rq_in_range && !active[rq_ch_ff[IDX_W-1:0]];
   assign scan_done   = (ptr_ff == CH_W'(DEPTH - 1));

   // The visited channel is the last of the tick when no higher channel is
   // active; higher channels do not change before they are visited.
   always_comb begin
      higher_active = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CH_W'(i) > ptr_ff) begin
            higher_active = higher_active | active[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rq_ch_in     = rq_ch_ff;
      rq_dir_in    = rq_dir_ff;
      rq_count_in  = rq_count_ff;
      rq_mem_in    = rq_mem_ff;
      rq_dev_in    = rq_dev_ff;
      rq_vec_in    = rq_vec_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_idx       = ptr_ff[IDX_W-1:0];
      wr_entry     = stepped;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rq_ch_in    = req_channel_index;
               rq_dir_in   = req_to_memory;
               rq_count_in = req_byte_count;
               rq_mem_in   = req_memory_start;
               rq_dev_in   = req_device_start;
               rq_vec_in   = req_interrupt_vector;
               ptr_in      = '0;
               if (req_opcode == OP_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_REQ;
               end
            end
         end

         ST_REQ: begin
            if (out_free) begin
               // Load the channel and answer in the same cycle.
               wr_en               = rq_ok;
               wr_idx              = rq_ch_ff[IDX_W-1:0];
               wr_entry.remaining  = rq_count_ff;
               wr_entry.mem_cursor = rq_mem_ff;
               wr_entry.dev_cursor = rq_dev_ff;
               wr_entry.direction  = rq_dir_ff;
               wr_entry.vector     = rq_vec_ff;
               out_valid_in        = 1'b1;
               out_in              = '0;
               out_in.kind         = KIND_ANSWER;
               out_in.accepted     = rq_ok;
               out_in.channel      = rq_ch_ff;
               out_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         ST_TICK: begin
            if (!active[ptr_ff[IDX_W-1:0]] || out_free) begin
               if (active[ptr_ff[IDX_W-1:0]]) begin
                  // One byte for this channel: write back the stepped context
                  // and issue the command with the pre-step addresses.
                  wr_en            = 1'b1;
                  out_valid_in     = 1'b1;
                  out_in.kind      = KIND_XFER;
                  out_in.accepted  = 1'b0;
                  out_in.channel   = ptr_ff;
                  out_in.direction = rd_entry.direction;
                  out_in.mem_addr  = rd_entry.mem_cursor;
                  out_in.dev_addr  = rd_entry.dev_cursor;
                  out_in.irq       = final_byte;
                  out_in.vector    = final_byte ? rd_entry.vector : '0;
                  out_in.last      = !higher_active;
               end
               if (scan_done) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + CH_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ch_ff    <= rq_ch_in;
      rq_dir_ff   <= rq_dir_in;
      rq_count_ff <= rq_count_in;
      rq_mem_ff   <= rq_mem_in;
      rq_dev_ff   <= rq_dev_in;
      rq_vec_ff   <= rq_vec_in;
      out_ff      <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_ff.kind;
   assign rsp_accepted        = out_ff.accepted;
   assign rsp_channel_out     = out_ff.channel;
   assign rsp_direction_out   = out_ff.direction;
   assign rsp_memory_address  = out_ff.mem_addr;
   assign rsp_device_address  = out_ff.dev_addr;
   assign rsp_raise_interrupt = out_ff.irq;
   assign rsp_vector_out      = out_ff.vector;
   assign rsp_last_of_run     = out_ff.last;

endmodule

`default_nettype wire
